[sv/mtc_pkg.sv]
// shared constants, types and lookup tables for the marching tetrahedra cube core
`timescale 1ns / 1ps
`default_nettype none
package mtc_pkg;

  // default configuration
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COORD_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF   = 8;

  // fixed port geometry
  localparam int CoordFieldW  = 8;
  localparam int SampleFieldW = 16;
  localparam int NumCorners   = 8;
  localparam int InDataW      = 3 * CoordFieldW + NumCorners * SampleFieldW;
  localparam int PosW         = 17;
  localparam int OutDataW     = ((3 * PosW + 7) / 8) * 8;
  localparam int ThrW         = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd32768;

  // queue between front and back
  localparam int QueueDepth = 4;

  // index of the last tetrahedron of a cube
  localparam logic [2:0] LastTet = 3'd5;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_PICK,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // corner i of tetrahedron t
  function automatic logic [2:0] tet_corner(input logic [2:0] t, input logic [1:0] i);
    logic [11:0] row;
    case (t)
      3'd0: row = {3'd6, 3'd3, 3'd2, 3'd0};
      3'd1: row = {3'd6, 3'd3, 3'd1, 3'd0};
      3'd2: row = {3'd6, 3'd4, 3'd0, 3'd1};
      3'd3: row = {3'd7, 3'd6, 3'd3, 3'd1};
      3'd4: row = {3'd7, 3'd6, 3'd4, 3'd1};
      3'd5: row = {3'd7, 3'd5, 3'd4, 3'd1};
      default: row = '0;
    endcase
    return row[3*i +: 3];
  endfunction

  // end point of a tetrahedron edge, as a local corner index
  function automatic logic [1:0] edge_end(input logic [2:0] e, input logic which);
    logic [3:0] ends;
    case (e)
      3'd0: ends = {2'd1, 2'd0};
      3'd1: ends = {2'd2, 2'd0};
      3'd2: ends = {2'd3, 2'd0};
      3'd3: ends = {2'd2, 2'd1};
      3'd4: ends = {2'd3, 2'd1};
      3'd5: ends = {2'd3, 2'd2};
      default: ends = '0;
    endcase
    return which ? ends[3:2] : ends[1:0];
  endfunction

  // vertices emitted for a pass mask
  function automatic logic [2:0] tri_count(input logic [3:0] m);
    logic [2:0] n;
    case (m)
      4'd0, 4'd15: n = 3'd0;
      4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: n = 3'd6;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  // edge of vertex i for a pass mask
  function automatic logic [2:0] tri_edge(input logic [3:0] m, input logic [2:0] i);
    logic [17:0] row;
    case (m)
      4'd1, 4'd14: row = {3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0};
      4'd2, 4'd13: row = {3'd0, 3'd0, 3'd0, 3'd4, 3'd3, 3'd0};
      4'd3:        row = {3'd4, 3'd3, 3'd2, 3'd3, 3'd2, 3'd1};
      4'd4, 4'd11: row = {3'd0, 3'd0, 3'd0, 3'd5, 3'd3, 3'd1};
      4'd5:        row = {3'd5, 3'd3, 3'd2, 3'd3, 3'd2, 3'd0};
      4'd6:        row = {3'd5, 3'd2, 3'd0, 3'd5, 3'd1, 3'd0};
      4'd7, 4'd8:  row = {3'd0, 3'd0, 3'd0, 3'd5, 3'd4, 3'd2};
      4'd9:        row = {3'd5, 3'd4, 3'd0, 3'd5, 3'd1, 3'd0};
      4'd10:       row = {3'd3, 3'd2, 3'd0, 3'd3, 3'd2, 3'd5};
      4'd12:       row = {3'd2, 3'd1, 3'd3, 3'd3, 3'd2, 3'd4};
      default:     row = '0;
    endcase
    return (i < 3'd6) ? row[3*i +: 3] : 3'd0;
  endfunction

  // pass mask of tetrahedron t
  function automatic logic [3:0] tet_mask(input logic [2:0] t, input logic [7:0] pass);
    logic [3:0] m;
    for (int i = 0; i < 4; i++) begin
      m[i] = pass[tet_corner(t, 2'(i))];
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[sv/mtc_queue.sv]
// small first-in first-out queue of edge jobs between front and back
`timescale 1ns / 1ps
`default_nettype none
module mtc_queue #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);
  import mtc_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  // handshake
  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= PtrW'((CntW'(wptr_q) + 1'b1) % CntW'(QueueDepth));
      if (pop) rptr_q <= PtrW'((CntW'(rptr_q) + 1'b1) % CntW'(QueueDepth));
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

[sv/mtc_front.sv]
// front: takes cubes, classifies corners and issues one job per triangle vertex
`timescale 1ns / 1ps
`default_nettype none
module mtc_front #(
  parameter int SampleBits = 16,
  parameter int CoordBits  = 8,
  parameter int JobW       = 3 * 8 + 2 * 16 + 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [mtc_pkg::ThrW-1:0]    thr_i,
  input  wire logic                        cube_valid_i,
  output logic                             cube_ready_o,
  input  wire logic [mtc_pkg::InDataW-1:0] cube_data_i,
  output logic                             job_valid_o,
  input  wire logic                        job_ready_i,
  output logic [JobW-1:0]                  job_data_o
);
  import mtc_pkg::*;

  front_state_e state_q, state_d;

  logic [SampleBits-1:0] samp_q [NumCorners];
  logic [CoordBits-1:0]  org_q [3];
  logic [7:0]            pass_q;
  logic [2:0]            tet_q, idx_q;
  logic [SampleBits-1:0] sa_q;

  logic [SampleBits-1:0] thr;
  logic [7:0]            pass_in;
  logic                  any_in;
  logic [3:0]            mask;
  logic [2:0]            cnt, edge_id, ca, cb;
  logic                  later, last_idx, last_job;
  logic                  accept, push;

  assign thr = SampleBits'(thr_i);

  // classify incoming corners
  always_comb begin
    any_in = 1'b0;
    for (int k = 0; k < NumCorners; k++) begin
      pass_in[k] = SampleBits'(cube_data_i[3*CoordFieldW + k*SampleFieldW +: SampleFieldW]) > thr;
    end
    for (int t = 0; t < 6; t++) begin
      if (tet_mask(3'(t), pass_in) != 4'd0 && tet_mask(3'(t), pass_in) != 4'd15) any_in = 1'b1;
    end
  end

  // current edge and whether it closes the cube
  always_comb begin
    mask     = tet_mask(tet_q, pass_q);
    cnt      = tri_count(mask);
    edge_id  = tri_edge(mask, idx_q);
    ca       = tet_corner(tet_q, edge_end(edge_id, 1'b0));
    cb       = tet_corner(tet_q, edge_end(edge_id, 1'b1));
    later    = 1'b0;
    for (int t = 0; t < 6; t++) begin
      if (3'(t) > tet_q && tri_count(tet_mask(3'(t), pass_q)) != 3'd0) later = 1'b1;
    end
    last_idx = (idx_q == cnt - 3'd1);
    last_job = last_idx && !later;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (cube_valid_i && any_in) state_d = FR_PICK;
      FR_PICK: begin
        if (cnt != 3'd0) state_d = FR_PUSH;
        else if (tet_q == LastTet) state_d = FR_IDLE;
      end
      FR_PUSH: if (job_ready_i) state_d = last_job ? FR_IDLE : FR_PICK;
      default: state_d = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cube_ready_o = 1'b0;
    job_valid_o  = 1'b0;
    case (state_q)
      FR_IDLE: cube_ready_o = 1'b1;
      FR_PUSH: job_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign accept = cube_valid_i && cube_ready_o;
  assign push   = job_valid_o && job_ready_i;

  assign job_data_o = {last_job, cb, ca, samp_q[cb], sa_q, org_q[2], org_q[1], org_q[0]};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      tet_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        tet_q <= '0;
        idx_q <= '0;
      end else if (state_q == FR_PICK && cnt == 3'd0) begin
        tet_q <= tet_q + 3'd1;
      end else if (push) begin
        if (last_idx) begin
          idx_q <= '0;
          tet_q <= tet_q + 3'd1;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  // cube payload and first edge sample
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pass_q <= pass_in;
      for (int c = 0; c < 3; c++) begin
        org_q[c] <= CoordBits'(cube_data_i[c*CoordFieldW +: CoordFieldW]);
      end
      for (int k = 0; k < NumCorners; k++) begin
        samp_q[k] <= SampleBits'(cube_data_i[3*CoordFieldW + k*SampleFieldW +: SampleFieldW]);
      end
    end
    if (state_q == FR_PICK) sa_q <= samp_q[ca];
  end

endmodule
`default_nettype wire

[sv/mtc_back.sv]
// back: inverse-lerp divide per edge job and vertex position output
`timescale 1ns / 1ps
`default_nettype none
module mtc_back #(
  parameter int SampleBits = 16,
  parameter int CoordBits  = 8,
  parameter int FracBits   = 8,
  parameter int JobW       = 3 * 8 + 2 * 16 + 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [mtc_pkg::ThrW-1:0]     thr_i,
  input  wire logic                         job_valid_i,
  output logic                              job_ready_o,
  input  wire logic [JobW-1:0]              job_data_i,
  output logic                              vtx_valid_o,
  input  wire logic                         vtx_ready_i,
  output logic [mtc_pkg::OutDataW-1:0]      vtx_data_o,
  output logic                              vtx_last_o
);
  import mtc_pkg::*;

  localparam int SaOff = 3 * CoordBits;
  localparam int SbOff = SaOff + SampleBits;
  localparam int CaOff = SbOff + SampleBits;
  localparam int CbOff = CaOff + 3;
  localparam int LsOff = CbOff + 3;
  localparam int CntW  = $clog2(FracBits + 1);
  localparam int FW    = FracBits + 1;
  localparam int PW    = CoordBits + FracBits + 1;

  back_state_e state_q, state_d;

  logic [SampleBits-1:0] den_q, rem_q;
  logic [FracBits-1:0]   quo_q;
  logic [CntW-1:0]       cnt_q;
  logic                  f_zero_q, f_one_q, last_q;
  logic [2:0]            ca_q, cb_q;
  logic [CoordBits-1:0]  org_q [3];

  logic                  out_valid_q, out_last_q;
  logic [OutDataW-1:0]   out_data_q;

  logic [SampleBits-1:0] thr, sa, sb;
  logic [SampleBits-1:0] num_d, den_d;
  logic                  zero_d, one_d;
  logic [SampleBits:0]   rem2, rsum;
  logic [FW-1:0]         f, g;
  logic [PW-1:0]         pos [3];
  logic                  take, load_out;

  assign thr = SampleBits'(thr_i);
  assign sa  = job_data_i[SaOff +: SampleBits];
  assign sb  = job_data_i[SbOff +: SampleBits];

  // divider setup from both edge samples
  always_comb begin
    num_d  = '0;
    den_d  = '0;
    zero_d = 1'b0;
    if (sa > sb) begin
      num_d  = thr - sb;
      den_d  = sa - sb;
      zero_d = thr < sb;
    end else if (sb > sa) begin
      num_d  = sb - thr;
      den_d  = sb - sa;
      zero_d = thr > sb;
    end else begin
      zero_d = 1'b1;
    end
    one_d = !zero_d && (num_d >= den_d);
  end

  // restoring divide step and rounding
  assign rem2 = {rem_q, 1'b0};
  assign rsum = {1'b0, rem_q} + {1'b0, den_q >> 1};

  always_comb begin
    if (f_zero_q) f = '0;
    else if (f_one_q) f = FW'(1) << FracBits;
    else f = {1'b0, quo_q} + FW'(rsum >= {1'b0, den_q});
    g = (FW'(1) << FracBits) - f;
    for (int c = 0; c < 3; c++) begin
      pos[c] = {1'b0, org_q[c], {FracBits{1'b0}}}
             + (ca_q[2-c] ? PW'(f) : '0) + (cb_q[2-c] ? PW'(g) : '0);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (job_valid_i) state_d = BK_DIV;
      BK_DIV:  if (cnt_q == CntW'(FracBits - 1)) state_d = BK_OUT;
      BK_OUT:  if (!out_valid_q || vtx_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready_o = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      BK_IDLE: job_ready_o = 1'b1;
      BK_OUT:  load_out = !out_valid_q || vtx_ready_i;
      default: ;
    endcase
  end

  assign take = job_valid_i && job_ready_o;

  // control registers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) cnt_q <= '0;
      else if (state_q == BK_DIV) cnt_q <= cnt_q + 1'b1;
      if (load_out) out_valid_q <= 1'b1;
      else if (vtx_ready_i) out_valid_q <= 1'b0;
    end
  end

  // divider datapath and job payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      den_q    <= den_d;
      rem_q    <= num_d;
      quo_q    <= '0;
      f_zero_q <= zero_d;
      f_one_q  <= one_d;
      ca_q     <= job_data_i[CaOff +: 3];
      cb_q     <= job_data_i[CbOff +: 3];
      last_q   <= job_data_i[LsOff];
      for (int c = 0; c < 3; c++) begin
        org_q[c] <= job_data_i[c*CoordBits +: CoordBits];
      end
    end else if (state_q == BK_DIV) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_q <= SampleBits'(rem2 - {1'b0, den_q});
        quo_q <= {quo_q[FracBits-2:0], 1'b1};
      end else begin
        rem_q <= SampleBits'(rem2);
        quo_q <= {quo_q[FracBits-2:0], 1'b0};
      end
    end
    if (load_out) begin
      out_data_q <= OutDataW'({PosW'(pos[2]), PosW'(pos[1]), PosW'(pos[0])});
      out_last_q <= last_q;
    end
  end

  assign vtx_valid_o = out_valid_q;
  assign vtx_data_o  = out_data_q;
  assign vtx_last_o  = out_last_q;

endmodule
`default_nettype wire

[sv/marching_tetrahedra_cube_core.sv]
// top level of the marching tetrahedra cube core
//
// s_axis carries one voxel cube per item: origin and eight corner samples.
// m_axis carries one triangle vertex per item, tlast on the final vertex of
// a cube; a cube with no surface crossing gives no vertex at all.
// cfg writes the iso threshold; it is always ready. It must be written only
// while the core is idle; the core itself does not enforce this.
// The front takes a cube, then steps through its tetrahedra: an empty one
// passes through FR_PICK alone and each vertex through FR_PICK and FR_PUSH,
// pushing one edge job per vertex into a four-entry queue. It takes the
// next cube once the last job is queued. The back runs a restoring divider,
// one quotient bit per cycle, and takes a new job only once the finished
// vertex is loaded into the output register; this divider sets the
// throughput of surface cubes.
// When m_axis stalls the finished vertex waits in the output register,
// the back holds its next vertex, the queue fills and then the front stops
// taking cubes. Reset empties queue and pipeline and sets the threshold
// to 32768.
`timescale 1ns / 1ps
`default_nettype none
module marching_tetrahedra_cube_core #(
  parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF,
  parameter int COORD_BITS  = mtc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = mtc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [mtc_pkg::ThrW-1:0]    cfg_data_i,   // threshold
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // cube_x, cube_y, cube_z, corner_value_0 .. corner_value_7
  input  wire logic [mtc_pkg::InDataW-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [mtc_pkg::OutDataW-1:0]     m_axis_tdata,  // pos_x, pos_y, pos_z, zero pad
  output logic                             m_axis_tlast   // last_vertex
);
  import mtc_pkg::*;

  localparam int JobW = 3 * COORD_BITS + 2 * SAMPLE_BITS + 7;

  logic [ThrW-1:0] thr_q;
  logic            job_in_valid, job_in_ready, job_out_valid, job_out_ready;
  logic [JobW-1:0] job_in_data, job_out_data;

  // threshold register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= ThrReset;
    else if (cfg_valid_i) thr_q <= cfg_data_i;
  end

  mtc_front #(
    .SampleBits(SAMPLE_BITS),
    .CoordBits (COORD_BITS),
    .JobW      (JobW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .cube_valid_i(s_axis_tvalid),
    .cube_ready_o(s_axis_tready),
    .cube_data_i (s_axis_tdata),
    .job_valid_o (job_in_valid),
    .job_ready_i (job_in_ready),
    .job_data_o  (job_in_data)
  );

  mtc_queue #(
    .Width(JobW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(job_in_valid),
    .push_ready_o(job_in_ready),
    .push_data_i (job_in_data),
    .pop_valid_o (job_out_valid),
    .pop_ready_i (job_out_ready),
    .pop_data_o  (job_out_data)
  );

  mtc_back #(
    .SampleBits(SAMPLE_BITS),
    .CoordBits (COORD_BITS),
    .FracBits  (FRAC_BITS),
    .JobW      (JobW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .thr_i      (thr_q),
    .job_valid_i(job_out_valid),
    .job_ready_o(job_out_ready),
    .job_data_i (job_out_data),
    .vtx_valid_o(m_axis_tvalid),
    .vtx_ready_i(m_axis_tready),
    .vtx_data_o (m_axis_tdata),
    .vtx_last_o (m_axis_tlast)
  );

  // front never issues jobs while it is open for a new cube
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !job_in_valid)
    else $error("front issued a job while idle");

  // a stalled job stays offered to the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_in_valid && !job_in_ready |=> job_in_valid && $stable(job_in_data))
    else $error("front dropped a stalled job");

  // an idle back with an empty queue starts no new vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_out_ready && !job_out_valid |=> !m_axis_tvalid || $past(m_axis_tvalid))
    else $error("vertex appeared without a job");

endmodule
`default_nettype wire
